@@ sv/segment_transform_project_macros.svh @@
`ifndef SEGMENT_TRANSFORM_PROJECT_MACROS_SVH
`define SEGMENT_TRANSFORM_PROJECT_MACROS_SVH

// Antecedent holds in a cycle, consequent holds in the same cycle.
`define STP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("segment transform check failed");

// Antecedent holds in a cycle, consequent holds from the next cycle on.
`define STP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("segment transform check failed");

`endif

@@ sv/stp_pkg.sv @@
package stp_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int COORD_FRAC  = 12;
    localparam int TRIG_FRAC   = 14;

    localparam int TW      = TRIG_FRAC + 2;     // Q1.TRIG_FRAC sine / cosine
    localparam int RW      = COORD_WIDTH + 3;   // scaled and rotated coordinate
    localparam int PIX_W   = 16;
    localparam int COL_W   = 8;
    localparam int SIN_N   = 91;
    localparam int SIN_IW  = $clog2(SIN_N);
    localparam int SIN_SH  = 30 - TRIG_FRAC;
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    localparam int ANG_W   = 9;
    localparam int ANG_XW  = ANG_W + 1;
    localparam int FLD_W   = 8;
    localparam int DIM_W   = 12;
    localparam int HALF_W  = DIM_W - 1;
    localparam int TOFF_W  = FLD_W + COORD_FRAC;

    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 3 * ANG_W;

    // Scaling: floor((c*s + 50) / 100) through a biased reciprocal multiply
    localparam int SCL_PW    = COORD_WIDTH + 10;
    localparam int SCL_UW    = COORD_WIDTH + 9;
    localparam int SCL_SHIFT = SCL_UW + 7;
    localparam int RECIP_W   = SCL_UW + 1;
    localparam longint unsigned SCL_RECIP =
        ((64'd1 << SCL_SHIFT) + 64'd99) / 64'd100;
    localparam longint SCL_QOFF = longint'(1) << (COORD_WIDTH + 1);
    localparam longint SCL_BIAS = 100 * SCL_QOFF + 50;

    // Projection widths
    localparam int DW    = RW + 7;
    localparam int NW    = DW + 12;
    localparam int QB    = PIX_W;
    localparam int CMP_W = DW + QB;

    localparam int SCL_LAT = 2;
    localparam int ROT_LAT = 2;
    localparam int PRJ_LAT = 4 + QB + 1;

    typedef logic signed [RW-1:0] t_coord;
    typedef logic [TW-1:0] t_sin_tab [0:SIN_N-1];

    typedef enum logic [CFG_IW-1:0] {
        CFG_TRANSLATION = 3'd0,
        CFG_ROTATION    = 3'd1,
        CFG_SCALE       = 3'd2,
        CFG_WIDTH       = 3'd3,
        CFG_HEIGHT      = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] start_x;
        logic signed [COORD_WIDTH-1:0] start_y;
        logic signed [COORD_WIDTH-1:0] start_z;
        logic signed [COORD_WIDTH-1:0] end_x;
        logic signed [COORD_WIDTH-1:0] end_y;
        logic signed [COORD_WIDTH-1:0] end_z;
        logic [COL_W-1:0]              red;
        logic [COL_W-1:0]              green;
        logic [COL_W-1:0]              blue;
    } t_item;

    typedef struct packed {
        logic signed [PIX_W-1:0] screen_start_x;
        logic signed [PIX_W-1:0] screen_start_y;
        logic signed [PIX_W-1:0] screen_end_x;
        logic signed [PIX_W-1:0] screen_end_y;
        logic [COL_W-1:0]        out_red;
        logic [COL_W-1:0]        out_green;
        logic [COL_W-1:0]        out_blue;
        logic                    clipped;
    } t_result;

    typedef struct packed {
        logic [2:0][FLD_W-1:0]  scale;
        logic [2:0][TW-1:0]     sin_v;
        logic [2:0][TW-1:0]     cos_v;
        logic [2:0][TOFF_W-1:0] toff;
        logic [HALF_W-1:0]      half_w;
        logic [HALF_W-1:0]      half_h;
    } t_cfg;

    // Taylor series in Q30, rounded to Q1.TRIG_FRAC; evaluated at elaboration
    function automatic t_sin_tab build_sin();
        t_sin_tab tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint acc;
        int k;
        for (int d = 0; d < SIN_N; d++) begin
            x    = (longint'(d) * PI_Q30) / 64'd180;
            x2   = (x * x) >> 30;
            term = x;
            acc  = longint'(x);
            for (k = 1; k < 20 && term != 0; k++) begin
                term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
                if (k[0]) begin
                    acc -= longint'(term);
                end else begin
                    acc += longint'(term);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            tab[d] = TW'((acc + (longint'(1) << (SIN_SH - 1))) >> SIN_SH);
        end
        return tab;
    endfunction

    localparam t_sin_tab SIN_TAB = build_sin();

    function automatic logic signed [TW-1:0] sin_deg(input logic [ANG_XW-1:0] ang);
        logic [ANG_XW-1:0] a;
        logic [ANG_XW-1:0] idx;
        logic              neg;
        logic [TW-1:0]     val;
        a = (ang >= 10'd360) ? ang - 10'd360 : ang;
        if (a <= 10'd90) begin
            idx = a;
            neg = 1'b0;
        end else if (a <= 10'd180) begin
            idx = 10'd180 - a;
            neg = 1'b0;
        end else if (a <= 10'd270) begin
            idx = a - 10'd180;
            neg = 1'b1;
        end else begin
            idx = 10'd360 - a;
            neg = 1'b1;
        end
        val = SIN_TAB[idx[SIN_IW-1:0]];
        return neg ? -$signed(val) : $signed(val);
    endfunction

endpackage

@@ sv/stp_config.sv @@
module stp_config import stp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data,
    output t_cfg              o_cfg
);

    logic [3*FLD_W-1:0] r_trans;
    logic [3*ANG_W-1:0] r_rot;
    logic [3*FLD_W-1:0] r_scale;
    logic [DIM_W-1:0]   r_width;
    logic [DIM_W-1:0]   r_height;
    t_cfg               r_cfg;
    t_cfg               n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trans  <= 24'h646464;
            r_rot    <= '0;
            r_scale  <= 24'h646464;
            r_width  <= 12'd640;
            r_height <= 12'd480;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TRANSLATION: r_trans  <= i_cfg_data[3*FLD_W-1:0];
                CFG_ROTATION:    r_rot    <= i_cfg_data;
                CFG_SCALE:       r_scale  <= i_cfg_data[3*FLD_W-1:0];
                CFG_WIDTH:       r_width  <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT:      r_height <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp fields and look up sine / cosine once per cycle
    always_comb begin
        logic [FLD_W-1:0]  s;
        logic [FLD_W-1:0]  t;
        logic [ANG_XW-1:0] a;
        n_cfg = '0;
        for (int i = 0; i < 3; i++) begin
            s = r_scale[i*FLD_W +: FLD_W];
            if (s == 8'd0) begin
                s = 8'd1;
            end else if (s > 8'd200) begin
                s = 8'd200;
            end
            t = r_trans[i*FLD_W +: FLD_W];
            if (t > 8'd200) begin
                t = 8'd200;
            end
            a = ANG_XW'(r_rot[i*ANG_W +: ANG_W]);
            if (a > 10'd360) begin
                a = 10'd360;
            end
            n_cfg.scale[i] = s;
            n_cfg.toff[i]  = (TOFF_W'(t) - TOFF_W'(100)) << COORD_FRAC;
            n_cfg.sin_v[i] = sin_deg(a);
            n_cfg.cos_v[i] = sin_deg(a + 10'd90);
        end
        n_cfg.half_w = r_width[DIM_W-1:1];
        n_cfg.half_h = r_height[DIM_W-1:1];
    end

    always_ff @(posedge i_clk) begin
        r_cfg <= n_cfg;
    end

endmodule

@@ sv/stp_scale.sv @@
module stp_scale import stp_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [COORD_WIDTH-1:0] i_coord,
    input  logic [FLD_W-1:0]              i_scale,
    output logic                          o_valid,
    output t_coord                        o_coord
);

    localparam logic signed [SCL_PW-1:0] BIAS = SCL_PW'(SCL_BIAS);
    localparam logic signed [RW-1:0]     QOFF = RW'(SCL_QOFF);
    localparam int                       PW2  = SCL_UW + RECIP_W;

    logic                    r_v1;
    logic                    r_v2;
    logic [SCL_UW-1:0]       r_u;
    t_coord                  r_c;
    logic signed [SCL_PW-1:0] n_prod;
    logic [PW2-1:0]          n_recip;

    // biased so the quotient is taken on a non-negative value
    assign n_prod  = SCL_PW'(i_coord) * $signed(SCL_PW'(i_scale)) + BIAS;
    assign n_recip = PW2'(r_u) * PW2'(SCL_RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u <= n_prod[SCL_UW-1:0];
        r_c <= $signed(n_recip[SCL_SHIFT +: RW]) - QOFF;
    end

    assign o_valid = r_v2;
    assign o_coord = r_c;

endmodule

@@ sv/stp_rotate.sv @@
module stp_rotate import stp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  t_coord               i_p,
    input  t_coord               i_q,
    input  t_coord               i_r,
    input  logic signed [TW-1:0] i_cos,
    input  logic signed [TW-1:0] i_sin,
    output logic                 o_valid,
    output t_coord               o_p,
    output t_coord               o_q,
    output t_coord               o_r
);

    localparam int MW  = RW + TW;
    localparam int SMW = MW + 1;
    localparam logic signed [SMW-1:0] RND = SMW'(64'd1 << (TRIG_FRAC - 1));

    logic                  r_v1;
    logic                  r_v2;
    logic signed [MW-1:0]  r_pc;
    logic signed [MW-1:0]  r_qs;
    logic signed [MW-1:0]  r_ps;
    logic signed [MW-1:0]  r_qc;
    t_coord                r_r1;
    t_coord                r_p2;
    t_coord                r_q2;
    t_coord                r_r2;
    logic signed [SMW-1:0] n_p;
    logic signed [SMW-1:0] n_q;

    // p' = c*p - s*q, q' = s*p + c*q, rounded back by half an LSB then floor
    assign n_p = (SMW'(r_pc) - SMW'(r_qs) + RND) >>> TRIG_FRAC;
    assign n_q = (SMW'(r_ps) + SMW'(r_qc) + RND) >>> TRIG_FRAC;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pc <= MW'(i_p) * MW'(i_cos);
        r_qs <= MW'(i_q) * MW'(i_sin);
        r_ps <= MW'(i_p) * MW'(i_sin);
        r_qc <= MW'(i_q) * MW'(i_cos);
        r_r1 <= i_r;
        r_p2 <= n_p[RW-1:0];
        r_q2 <= n_q[RW-1:0];
        r_r2 <= r_r1;
    end

    assign o_valid = r_v2;
    assign o_p     = r_p2;
    assign o_q     = r_q2;
    assign o_r     = r_r2;

endmodule

@@ sv/stp_project.sv @@
module stp_project import stp_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  t_coord                   i_v,
    input  t_coord                   i_z,
    input  logic signed [TOFF_W-1:0] i_toff_v,
    input  logic signed [TOFF_W-1:0] i_toff_z,
    input  logic [HALF_W-1:0]        i_half,
    output logic                     o_valid,
    output logic signed [PIX_W-1:0]  o_pix,
    output logic                     o_ok
);

    localparam logic signed [DW-1:0] K50       = 50;
    localparam logic signed [DW-1:0] DEPTH_OFF = DW'(250 * (2 ** COORD_FRAC));
    localparam logic signed [NW-1:0] K200      = 200;
    localparam logic [QB-1:0]        QMAX_NEG  = {1'b1, {(QB-1){1'b0}}};
    localparam logic [QB-1:0]        QMAX_POS  = {1'b0, {(QB-1){1'b1}}};

    // front stages: numerator and depth, then N = 200*X + half*D and |N|
    logic                  r_v1, r_v2, r_v3;
    logic signed [DW-1:0]  r_x, r_d;
    logic signed [NW-1:0]  r_num, r_hd;
    logic signed [DW-1:0]  r_d2;
    logic                  r_dpos2;
    logic [NW-1:0]         r_mag3;
    logic [DW-2:0]         r_d3;
    logic                  r_neg3, r_ok3;
    logic signed [NW-1:0]  n_n2;

    // divider stages, index 0 is the overflow check stage
    logic                  r_vd  [0:QB];
    logic [CMP_W-1:0]      r_rem [0:QB];
    logic [DW-2:0]         r_dd  [0:QB];
    logic [QB-1:0]         r_q   [0:QB];
    logic                  r_neg [0:QB];
    logic                  r_okd [0:QB];

    logic                  r_v5;
    logic signed [PIX_W-1:0] r_pix;
    logic                  r_ok5;

    assign n_n2 = r_num + r_hd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_vd[0] <= 1'b0;
            r_v5    <= 1'b0;
        end else begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_vd[0] <= r_v3;
            r_v5    <= r_vd[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        r_x     <= K50 * DW'(i_v) + DW'(i_toff_v);
        r_d     <= K50 * DW'(i_z) + DW'(i_toff_z) + DEPTH_OFF;
        r_num   <= K200 * NW'(r_x);
        r_hd    <= $signed(NW'(i_half)) * NW'(r_d);
        r_d2    <= r_d;
        r_dpos2 <= (r_d > 0);
        r_neg3  <= n_n2[NW-1];
        r_mag3  <= n_n2[NW-1] ? NW'(-n_n2) : NW'(n_n2);
        r_d3    <= r_d2[DW-2:0];
        r_ok3   <= r_dpos2;
        // a quotient of 2^QB or more clears the ok flag whatever the sign
        r_rem[0] <= CMP_W'(r_mag3);
        r_dd[0]  <= r_d3;
        r_q[0]   <= '0;
        r_neg[0] <= r_neg3;
        r_okd[0] <= r_ok3 && (CMP_W'(r_mag3) < (CMP_W'(r_d3) << QB));
    end

    for (genvar i = 0; i < QB; i++) begin : g_div
        logic [CMP_W-1:0] trial;
        logic             take;
        assign trial = CMP_W'(r_dd[i]) << (QB - 1 - i);
        assign take  = (r_rem[i] >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vd[i+1] <= 1'b0;
            end else begin
                r_vd[i+1] <= r_vd[i];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[i+1] <= take ? r_rem[i] - trial : r_rem[i];
            r_q[i+1]   <= {r_q[i][QB-2:0], take};
            r_dd[i+1]  <= r_dd[i];
            r_neg[i+1] <= r_neg[i];
            r_okd[i+1] <= r_okd[i];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix <= r_neg[QB] ? -$signed(r_q[QB]) : $signed(r_q[QB]);
        r_ok5 <= r_okd[QB] && (r_neg[QB] ? (r_q[QB] <= QMAX_NEG) : (r_q[QB] <= QMAX_POS));
    end

    assign o_valid = r_v5;
    assign o_pix   = r_pix;
    assign o_ok    = r_ok5;

endmodule

@@ sv/segment_transform_project.sv @@
// Channel     | Direction | Handshake                     | Payload
// ------------+-----------+-------------------------------+---------------------------
// item in     | in        | start high while busy low     | i_item (t_item)
// result out  | out       | o_valid, one cycle, no stall  | o_result (t_result)
// config      | in        | i_cfg_valid and o_cfg_ready   | i_cfg_index, i_cfg_data
//
// One segment is taken every cycle; busy stays low and nothing blocks entry.
// From the accepting edge to o_valid a segment passes the input register,
// two scaling stages, three rotations of two stages, 21 projection stages
// (16 of them one quotient bit each of the shared-nothing restoring divider),
// and the output register.
// Reset is synchronous; it clears all valid bits and loads the register defaults.
// The receiver cannot stall, so every pipeline stage advances each cycle.
`include "segment_transform_project_macros.svh"

module segment_transform_project import stp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_item             i_item,
    output logic              o_valid,
    output t_result           o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    localparam int LATENCY = 2 + SCL_LAT + 3 * ROT_LAT + PRJ_LAT;
    localparam int COL_DLY = LATENCY - 2;

    t_cfg    cfg;
    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    logic [3*COL_W-1:0] r_col [0:COL_DLY-1];

    logic signed [COORD_WIDTH-1:0] in_c [0:1][0:2];
    logic   sc_v  [0:1][0:2];
    t_coord sc_c  [0:1][0:2];
    logic   rx_v  [0:1];
    t_coord rx_p  [0:1], rx_q [0:1], rx_r [0:1];
    logic   ry_v  [0:1];
    t_coord ry_p  [0:1], ry_q [0:1], ry_r [0:1];
    logic   rz_v  [0:1];
    t_coord rz_p  [0:1], rz_q [0:1], rz_r [0:1];
    logic   pj_v  [0:1][0:1];
    logic   pj_ok [0:1][0:1];
    logic signed [PIX_W-1:0] pj_pix [0:1][0:1];

    logic    n_clip;

    assign busy = 1'b0;

    stp_config u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in <= i_item;
        end
    end

    assign in_c[0][0] = r_in.start_x;
    assign in_c[0][1] = r_in.start_y;
    assign in_c[0][2] = r_in.start_z;
    assign in_c[1][0] = r_in.end_x;
    assign in_c[1][1] = r_in.end_y;
    assign in_c[1][2] = r_in.end_z;

    for (genvar e = 0; e < 2; e++) begin : g_ep
        for (genvar a = 0; a < 3; a++) begin : g_axis
            stp_scale u_scale (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (r_in_valid),
                .i_coord (in_c[e][a]),
                .i_scale (cfg.scale[a]),
                .o_valid (sc_v[e][a]),
                .o_coord (sc_c[e][a])
            );
        end

        // about X: (y, z) turn, x rides along
        stp_rotate u_rot_x (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (sc_v[e][0] && sc_v[e][1] && sc_v[e][2]),
            .i_p     (sc_c[e][1]),
            .i_q     (sc_c[e][2]),
            .i_r     (sc_c[e][0]),
            .i_cos   ($signed(cfg.cos_v[0])),
            .i_sin   ($signed(cfg.sin_v[0])),
            .o_valid (rx_v[e]),
            .o_p     (rx_p[e]),
            .o_q     (rx_q[e]),
            .o_r     (rx_r[e])
        );

        // about Y: (z, x) turn, y rides along
        stp_rotate u_rot_y (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (rx_v[e]),
            .i_p     (rx_q[e]),
            .i_q     (rx_r[e]),
            .i_r     (rx_p[e]),
            .i_cos   ($signed(cfg.cos_v[1])),
            .i_sin   ($signed(cfg.sin_v[1])),
            .o_valid (ry_v[e]),
            .o_p     (ry_p[e]),
            .o_q     (ry_q[e]),
            .o_r     (ry_r[e])
        );

        // about Z: (x, y) turn, z rides along
        stp_rotate u_rot_z (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (ry_v[e]),
            .i_p     (ry_q[e]),
            .i_q     (ry_r[e]),
            .i_r     (ry_p[e]),
            .i_cos   ($signed(cfg.cos_v[2])),
            .i_sin   ($signed(cfg.sin_v[2])),
            .o_valid (rz_v[e]),
            .o_p     (rz_p[e]),
            .o_q     (rz_q[e]),
            .o_r     (rz_r[e])
        );

        stp_project u_prj_x (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (rz_v[e]),
            .i_v      (rz_p[e]),
            .i_z      (rz_r[e]),
            .i_toff_v ($signed(cfg.toff[0])),
            .i_toff_z ($signed(cfg.toff[2])),
            .i_half   (cfg.half_w),
            .o_valid  (pj_v[e][0]),
            .o_pix    (pj_pix[e][0]),
            .o_ok     (pj_ok[e][0])
        );

        stp_project u_prj_y (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (rz_v[e]),
            .i_v      (rz_q[e]),
            .i_z      (rz_r[e]),
            .i_toff_v ($signed(cfg.toff[1])),
            .i_toff_z ($signed(cfg.toff[2])),
            .i_half   (cfg.half_h),
            .o_valid  (pj_v[e][1]),
            .o_pix    (pj_pix[e][1]),
            .o_ok     (pj_ok[e][1])
        );
    end

    // color follows the datapath in a plain delay line
    always_ff @(posedge i_clk) begin
        r_col[0] <= {r_in.red, r_in.green, r_in.blue};
    end

    for (genvar i = 1; i < COL_DLY; i++) begin : g_col
        always_ff @(posedge i_clk) begin
            r_col[i] <= r_col[i-1];
        end
    end

    assign n_clip = !(pj_ok[0][0] && pj_ok[0][1] && pj_ok[1][0] && pj_ok[1][1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= pj_v[0][0] && pj_v[0][1] && pj_v[1][0] && pj_v[1][1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.screen_start_x <= n_clip ? '0 : pj_pix[0][0];
        r_out.screen_start_y <= n_clip ? '0 : pj_pix[0][1];
        r_out.screen_end_x   <= n_clip ? '0 : pj_pix[1][0];
        r_out.screen_end_y   <= n_clip ? '0 : pj_pix[1][1];
        r_out.out_red        <= r_col[COL_DLY-1][3*COL_W-1:2*COL_W];
        r_out.out_green      <= r_col[COL_DLY-1][2*COL_W-1:COL_W];
        r_out.out_blue       <= r_col[COL_DLY-1][COL_W-1:0];
        r_out.clipped        <= n_clip;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    `STP_ASSERT_IMP(a_out_from_accept, i_clk, i_rst_n, o_valid, $past(start && !busy, LATENCY))
    `STP_ASSERT_NEXT(a_accept_to_out, i_clk, i_rst_n, start && !busy, ##(LATENCY-1) o_valid)
    `STP_ASSERT_IMP(a_clip_zero, i_clk, i_rst_n, o_valid && o_result.clipped, o_result.screen_start_x == 0 && o_result.screen_start_y == 0 && o_result.screen_end_x == 0 && o_result.screen_end_y == 0)
    `STP_ASSERT_IMP(a_color_pass, i_clk, i_rst_n, o_valid, o_result.out_red == $past(i_item.red, LATENCY) && o_result.out_green == $past(i_item.green, LATENCY) && o_result.out_blue == $past(i_item.blue, LATENCY))

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import stp_pkg::*;

    class projection_board;
        t_result           expected_screens[$];
        int                mismatches;
        logic [23:0]       translation;
        logic [26:0]       rotation;
        logic [23:0]       scale;
        logic [11:0]       width;
        logic [11:0]       height;
        longint            sine_q14[0:90];

        function new();
            longint unsigned x;
            longint unsigned x2;
            longint unsigned term;
            longint          acc;
            mismatches  = 0;
            translation = 24'h646464;
            rotation    = '0;
            scale       = 24'h646464;
            width       = 12'd640;
            height      = 12'd480;
            // Taylor series in Q30, rounded to nearest Q1.14
            for (int d = 0; d <= 90; d++) begin
                x    = (longint'(d) * 64'd3373259426) / 64'd180;
                x2   = (x * x) >> 30;
                term = x;
                acc  = longint'(x);
                for (int k = 1; k < 20 && term != 0; k++) begin
                    term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
                    if (k % 2 == 1) acc -= longint'(term);
                    else acc += longint'(term);
                end
                if (acc < 0) acc = 0;
                sine_q14[d] = (acc + (longint'(1) << 15)) >>> 16;
            end
        endfunction

        function void set_cfg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
            case (idx)
                CFG_TRANSLATION: translation = data[23:0];
                CFG_ROTATION:    rotation    = data[26:0];
                CFG_SCALE:       scale       = data[23:0];
                CFG_WIDTH:       width       = data[11:0];
                CFG_HEIGHT:      height      = data[11:0];
                default: ;
            endcase
        endfunction

        function longint sine(int unsigned a);
            a = a % 360;
            if (a <= 90) return sine_q14[a];
            if (a <= 180) return sine_q14[180 - a];
            if (a <= 270) return -sine_q14[a - 180];
            return -sine_q14[360 - a];
        endfunction

        function longint fdiv(longint a, longint b);
            longint q;
            q = a / b;
            if ((a % b) != 0 && a < 0) q--;
            return q;
        endfunction

        function longint trig_round(longint v);
            return fdiv(v + 8192, 16384);
        endfunction

        function int unsigned angle(int pos);
            int unsigned a;
            a = (rotation >> pos) & 9'h1ff;
            return (a > 360) ? 360 : a;
        endfunction

        function longint scale_of(int pos);
            longint s;
            s = (scale >> pos) & 8'hff;
            if (s == 0) s = 1;
            if (s > 200) s = 200;
            return s;
        endfunction

        function longint offset_of(int pos);
            longint t;
            t = (translation >> pos) & 8'hff;
            if (t > 200) t = 200;
            return (t - 100) * 4096;
        endfunction

        function bit to_screen(longint num50, longint den, longint half, output longint pix);
            longint num;
            longint q;
            longint r;
            longint v;
            pix = 0;
            if (den <= 0) return 0;
            num = 200 * num50;
            q   = fdiv(num, den);
            r   = num - q * den;
            v   = q + half;
            if (v < 0 && r != 0) v++;
            if (v > 32767 || v < -32768) return 0;
            pix = v;
            return 1;
        endfunction

        function bit place_vertex(longint x, longint y, longint z,
                                  output longint sx, output longint sy);
            longint s;
            longint c;
            longint nx;
            longint ny;
            longint nz;
            longint den;
            sy = 0;
            x = fdiv(x * scale_of(0) + 50, 100);
            y = fdiv(y * scale_of(8) + 50, 100);
            z = fdiv(z * scale_of(16) + 50, 100);
            s = sine(angle(0)); c = sine(angle(0) + 90);
            ny = trig_round(c * y - s * z);
            nz = trig_round(s * y + c * z);
            y = ny; z = nz;
            s = sine(angle(9)); c = sine(angle(9) + 90);
            nx = trig_round(c * x + s * z);
            nz = trig_round(c * z - s * x);
            x = nx; z = nz;
            s = sine(angle(18)); c = sine(angle(18) + 90);
            nx = trig_round(c * x - s * y);
            ny = trig_round(s * x + c * y);
            x = nx; y = ny;
            den = 50 * z + offset_of(16) + 250 * 4096;
            if (!to_screen(50 * x + offset_of(0), den, longint'(width >> 1), sx)) return 0;
            return to_screen(50 * y + offset_of(8), den, longint'(height >> 1), sy);
        endfunction

        function void note(t_item it);
            t_result e;
            longint  p[4];
            bit      ok;
            ok = place_vertex(longint'(it.start_x), longint'(it.start_y),
                              longint'(it.start_z), p[0], p[1]);
            if (!place_vertex(longint'(it.end_x), longint'(it.end_y),
                              longint'(it.end_z), p[2], p[3])) ok = 0;
            e.screen_start_x = ok ? p[0][15:0] : '0;
            e.screen_start_y = ok ? p[1][15:0] : '0;
            e.screen_end_x   = ok ? p[2][15:0] : '0;
            e.screen_end_y   = ok ? p[3][15:0] : '0;
            e.out_red        = it.red;
            e.out_green      = it.green;
            e.out_blue       = it.blue;
            e.clipped        = !ok;
            expected_screens = {expected_screens, e};
        endfunction

        function void check(t_result r);
            t_result e;
            if (expected_screens.size() == 0) begin
                $error("unexpected result transaction %h", r);
                mismatches++;
                return;
            end
            e = expected_screens.pop_front();
            if (r.screen_start_x !== e.screen_start_x) begin
                $error("screen_start_x exp %0d got %0d", e.screen_start_x, r.screen_start_x);
                mismatches++;
            end
            if (r.screen_start_y !== e.screen_start_y) begin
                $error("screen_start_y exp %0d got %0d", e.screen_start_y, r.screen_start_y);
                mismatches++;
            end
            if (r.screen_end_x !== e.screen_end_x) begin
                $error("screen_end_x exp %0d got %0d", e.screen_end_x, r.screen_end_x);
                mismatches++;
            end
            if (r.screen_end_y !== e.screen_end_y) begin
                $error("screen_end_y exp %0d got %0d", e.screen_end_y, r.screen_end_y);
                mismatches++;
            end
            if (r.out_red !== e.out_red) begin
                $error("out_red exp %0d got %0d", e.out_red, r.out_red);
                mismatches++;
            end
            if (r.out_green !== e.out_green) begin
                $error("out_green exp %0d got %0d", e.out_green, r.out_green);
                mismatches++;
            end
            if (r.out_blue !== e.out_blue) begin
                $error("out_blue exp %0d got %0d", e.out_blue, r.out_blue);
                mismatches++;
            end
            if (r.clipped !== e.clipped) begin
                $error("clipped exp %0d got %0d", e.clipped, r.clipped);
                mismatches++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    t_item             i_item = '0;
    logic              o_valid;
    t_result           o_result;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CFG_IW-1:0] i_cfg_index = '0;
    logic [CFG_DW-1:0] i_cfg_data = '0;

    projection_board board = new();
    int              idle_pct;

    always #6 i_clk = ~i_clk;

    segment_transform_project dut (.*);

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) board.check(o_result);
    end

    task automatic send_segment(t_item it);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        board.note(it);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
        @(negedge i_clk);
        start       <= 1'b0;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_cfg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (board.expected_screens.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [15:0] coord();
        if ($urandom_range(7) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(24000)) - 12000);
    endfunction

    function automatic t_item any_segment();
        t_item it;
        it.start_x = coord(); it.start_y = coord(); it.start_z = coord();
        it.end_x   = coord(); it.end_y   = coord(); it.end_z   = coord();
        it.red = 8'($urandom); it.green = 8'($urandom); it.blue = 8'($urandom);
        return it;
    endfunction

    function automatic t_item uniform_segment(logic [15:0] c, logic [7:0] col);
        t_item it;
        it = {c, c, c, c, c, c, col, col, col};
        return it;
    endfunction

    function automatic logic [26:0] angles();
        logic [26:0] a;
        for (int i = 0; i < 3; i++)
            a[9*i +: 9] = ($urandom_range(9) == 0) ? 9'($urandom) : 9'($urandom_range(360));
        return a;
    endfunction

    initial begin
        t_item it;
        idle_pct = 24;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // corners under reset settings: extremes, bit patterns, zero and tiny depth
        send_segment(uniform_segment(16'h0000, 8'h00));
        send_segment(uniform_segment(16'h7fff, 8'hff));
        send_segment(uniform_segment(16'h8000, 8'h00));
        send_segment(uniform_segment(16'h5555, 8'h55));
        send_segment(uniform_segment(16'haaaa, 8'haa));
        it = uniform_segment(16'h1000, 8'h12);
        it.start_z = -16'sd20480;
        send_segment(it);
        it.start_z = -16'sd20479;
        send_segment(it);
        it.end_z = -16'sd20400;
        it.start_z = 16'sd0;
        send_segment(it);
        it = any_segment();
        it.start_x = 16'h7fff; it.end_y = 16'h8000;
        send_segment(it);
        drain();

        // extremes: everything saturates, angles clamp to 360, out-of-range index
        write_reg(CFG_TRANSLATION, 27'hffffff);
        write_reg(CFG_ROTATION, 27'h7ffffff);
        write_reg(CFG_SCALE, 27'hffffff);
        write_reg(CFG_WIDTH, 27'hfff);
        write_reg(CFG_HEIGHT, 27'hfff);
        write_reg(CFG_HEIGHT + 3'd1, 27'h0);
        send_segment(uniform_segment(16'h7fff, 8'h0f));
        send_segment(uniform_segment(16'h8000, 8'hf0));
        for (int i = 0; i < 6; i++) send_segment(any_segment());
        drain();

        for (int phase = 0; phase < 9; phase++) begin
            idle_pct = (phase < 3) ? 24 : (phase < 6) ? 72 : 0;
            if (phase == 1) begin
                write_reg(CFG_TRANSLATION, 27'h0);
                write_reg(CFG_ROTATION, 27'h0);
                write_reg(CFG_SCALE, 27'h0);
                write_reg(CFG_WIDTH, 27'h0);
                write_reg(CFG_HEIGHT, 27'h0);
            end else begin
                write_reg(CFG_TRANSLATION, 27'($urandom_range(200) |
                          ($urandom_range(200) << 8) | ($urandom_range(255) << 16)));
                write_reg(CFG_ROTATION, angles());
                write_reg(CFG_SCALE, 27'($urandom_range(255) |
                          ($urandom_range(255) << 8) | ($urandom_range(255) << 16)));
                write_reg(CFG_WIDTH, 27'($urandom_range(4095)));
                write_reg(CFG_HEIGHT, 27'($urandom_range(4095)));
                write_reg(3'(CFG_HEIGHT + 1 + $urandom_range(2)), 27'($urandom));
            end
            for (int i = 0; i < 155; i++) send_segment(any_segment());
            // hold off until the pipe is empty before touching the registers
            drain();
        end

        if (board.mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
